>>> sv/clut_pixel_color_mapper_unit_assert.svh
// assertion macros for the colour lookup mapper
`ifndef CLUT_PIXEL_COLOR_MAPPER_UNIT_ASSERT_SVH
`define CLUT_PIXEL_COLOR_MAPPER_UNIT_ASSERT_SVH

// implication in the same cycle
`define CPCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cpcm assertion failed");

// implication in the next cycle
`define CPCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cpcm assertion failed");

`endif

>>> sv/cpcm_pkg.sv
// shared constants and colour conversion functions for the colour lookup mapper
package cpcm_pkg;

    localparam int CPCM_TABLE_ENTRIES = 32;

    localparam logic [1:0] FMT_1555 = 2'd0;
    localparam logic [1:0] FMT_565  = 2'd1;
    localparam logic [1:0] FMT_8888 = 2'd2;

    localparam logic [1:0] CFG_OUT_FORMAT   = 2'd0;
    localparam logic [1:0] CFG_BIT15_BYPASS = 2'd1;
    localparam logic [1:0] CFG_FORCE_FIXED  = 2'd2;
    localparam logic [1:0] CFG_DMA_ENABLE   = 2'd3;

    localparam logic [2:0] KIND_ALL   = 3'd0;
    localparam logic [2:0] KIND_BLUE  = 3'd1;
    localparam logic [2:0] KIND_GREEN = 3'd2;
    localparam logic [2:0] KIND_RED   = 3'd3;
    localparam logic [2:0] KIND_BG    = 3'd7;

    function automatic logic [31:0] f_encode8(input logic [1:0] fmt, input logic [7:0] r,
                                              input logic [7:0] g, input logic [7:0] b);
        logic [31:0] res;
        case (fmt)
            FMT_1555: res = {17'd0, r[7:3], g[7:3], b[7:3]};
            FMT_565:  res = {16'd0, r[7:3], g[7:2], b[7:3]};
            default:  res = {8'd0, r, g, b};
        endcase
        return res;
    endfunction

    function automatic logic [31:0] f_expand(input logic [1:0] fmt, input logic [15:0] p);
        logic [31:0] res;
        case (fmt)
            FMT_1555: res = {17'd0, p[14:0]};
            FMT_565:  res = {16'd0, p[14:5], 1'b0, p[4:0]};
            default:  res = {8'd0, p[14:10], 3'd0, p[9:5], 3'd0, p[4:0], 3'd0};
        endcase
        return res;
    endfunction

endpackage

>>> sv/cpcm_table.sv
// one colour channel lookup table: synchronous memory with per-entry valid bits
module cpcm_table import cpcm_pkg::*; #(
    parameter int TABLE_ENTRIES = CPCM_TABLE_ENTRIES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] i_waddr,
    input  logic [7:0]                       i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] i_raddr,
    output logic [7:0]                       o_rdata
);

    logic [7:0]               r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_vld;
    logic [7:0]               r_rdata;
    logic                     r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // entries not yet written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : 8'd0;

endmodule

>>> sv/clut_pixel_color_mapper_unit.sv
// colour lookup mapper top level: request decode, table memories and result pipeline
// pixel path: accepted requests pass stage r_s1, then output register r_o; i_stall can hold them
// throughput: one request per cycle when o_stall is low, pixels and colour words mixed; colour words give no result
// table reads register at the accepting edge, the conversion is registered once the output stage is free
// reset: tables read as zero, background word zero, format xrgb8888, dma on, other modes off
// reset is synchronous and active low; no clearing pass follows
module clut_pixel_color_mapper_unit import cpcm_pkg::*; #(
    parameter int TABLE_ENTRIES = CPCM_TABLE_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [15:0] i_pixel,
    input  logic [31:0] i_ctrl_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_color,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [1:0]  i_cfg_data
);

    `include "clut_pixel_color_mapper_unit_assert.svh"

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic [1:0]  r_out_fmt;
    logic        r_bypass;
    logic        r_force;
    logic        r_dma;
    logic [31:0] r_bg;

    logic        r_s1_valid;
    logic [15:0] r_s1_pix;
    logic        r_o_valid;
    logic [31:0] r_o_color;

    logic        s2_free;
    logic        in_acc;
    logic        pix_acc;
    logic        word_acc;
    logic [2:0]  kind;
    logic [4:0]  pix_r;
    logic [4:0]  pix_g;
    logic [4:0]  pix_b;
    logic [4:0]  word_addr;
    logic        we_r;
    logic        we_g;
    logic        we_b;
    logic [7:0]  rd_r;
    logic [7:0]  rd_g;
    logic [7:0]  rd_b;
    logic [31:0] n_color;

    assign s2_free  = !r_o_valid || !i_stall;
    assign o_stall  = r_s1_valid && !s2_free;
    assign in_acc   = i_valid && !o_stall;
    assign pix_acc  = in_acc && !i_mode;
    assign word_acc = in_acc && i_mode;

    assign kind      = i_ctrl_word[31:29];
    assign word_addr = i_ctrl_word[28:24];
    assign pix_r     = i_pixel[14:10];
    assign pix_g     = i_pixel[9:5];
    assign pix_b     = i_pixel[4:0];

    assign we_r = word_acc && (kind == KIND_ALL || kind == KIND_RED);
    assign we_g = word_acc && (kind == KIND_ALL || kind == KIND_GREEN);
    assign we_b = word_acc && (kind == KIND_ALL || kind == KIND_BLUE);

    cpcm_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (we_r),
        .i_waddr (word_addr[AW-1:0]),
        .i_wdata (i_ctrl_word[23:16]),
        .i_re    (pix_acc),
        .i_raddr (pix_r[AW-1:0]),
        .o_rdata (rd_r)
    );

    cpcm_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (we_g),
        .i_waddr (word_addr[AW-1:0]),
        .i_wdata (i_ctrl_word[15:8]),
        .i_re    (pix_acc),
        .i_raddr (pix_g[AW-1:0]),
        .o_rdata (rd_g)
    );

    cpcm_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_blue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (we_b),
        .i_waddr (word_addr[AW-1:0]),
        .i_wdata (i_ctrl_word[7:0]),
        .i_re    (pix_acc),
        .i_raddr (pix_b[AW-1:0]),
        .o_rdata (rd_b)
    );

    // pixel decision in priority order
    always_comb begin
        if (!r_dma) begin
            n_color = 32'd0;
        end else if (r_force) begin
            n_color = f_expand(r_out_fmt, r_s1_pix);
        end else if (r_s1_pix == 16'd0) begin
            if (r_out_fmt == FMT_1555 || r_out_fmt == FMT_565) begin
                n_color = f_encode8(r_out_fmt, r_bg[23:16], r_bg[15:8], r_bg[7:0]);
            end else begin
                n_color = r_bg;
            end
        end else if (r_bypass && r_s1_pix[15]) begin
            n_color = f_expand(r_out_fmt, r_s1_pix);
        end else begin
            n_color = f_encode8(r_out_fmt, rd_r, rd_g, rd_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_fmt  <= FMT_8888;
            r_bypass   <= 1'b0;
            r_force    <= 1'b0;
            r_dma      <= 1'b1;
            r_bg       <= 32'd0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OUT_FORMAT:   r_out_fmt <= i_cfg_data;
                    CFG_BIT15_BYPASS: r_bypass  <= i_cfg_data[0];
                    CFG_FORCE_FIXED:  r_force   <= i_cfg_data[0];
                    CFG_DMA_ENABLE:   r_dma     <= i_cfg_data[0];
                    default:          r_dma     <= r_dma;
                endcase
            end
            if (word_acc && kind == KIND_BG) begin
                r_bg <= i_ctrl_word;
            end
            if (pix_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s2_free) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_free) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_pix <= i_pixel;
        end
        if (s2_free && r_s1_valid) begin
            r_o_color <= n_color;
        end
    end

    assign o_valid = r_o_valid;
    assign o_color = r_o_color;

    `CPCM_ASSERT_NEXT(a_word_no_result, word_acc, !r_s1_valid)
    `CPCM_ASSERT_NEXT(a_pixel_staged, pix_acc, r_s1_valid)
    `CPCM_ASSERT_NEXT(a_dma_off_black, s2_free && r_s1_valid && !r_dma,
                      o_valid && o_color == 32'd0)

endmodule
